/* rtl/core/btl_pkg.sv */
// Shared types, constants and lane functions of the balanced-ternary logic unit.
package btl_pkg;

    // Number of trit lanes and the width of the incoming words
    localparam int TRIT_LANES = 27;
    localparam int OPERAND_W  = 64;

    // Power of three, evaluated at elaboration only
    function automatic longint pow3(input int n);
        longint p;
        p = 1;
        for (int i = 0; i < n; i++) begin
            p = p * 3;
        end
        return p;
    endfunction

    // Largest magnitude that TRIT_LANES balanced trits can hold
    localparam longint TRIT_MAX = (pow3(TRIT_LANES) - 1) / 2;

    // Smallest two's complement width that holds [-TRIT_MAX, TRIT_MAX]
    function automatic int calc_res_w(input longint m);
        int w;
        w = 0;
        for (int i = 1; i < 64; i++) begin
            if (w == 0 && (longint'(1) <<< (i - 1)) > m) begin
                w = i;
            end
        end
        if (w == 0) begin
            w = 64;
        end
        return w;
    endfunction

    localparam int RES_W = calc_res_w(TRIT_MAX);
    localparam int CNT_W = $clog2(TRIT_LANES + 1);

    // Operation codes
    localparam logic [2:0] FUNC_AND = 3'd0;
    localparam logic [2:0] FUNC_OR  = 3'd1;
    localparam logic [2:0] FUNC_XOR = 3'd2;
    localparam logic [2:0] FUNC_IMP = 3'd3;
    localparam logic [2:0] FUNC_CMP = 3'd4;
    localparam logic [2:0] FUNC_POP = 3'd5;

    // Data handed from one lane cell to the next
    typedef struct packed {
        logic [2:0]              func;
        logic signed [1:0]       want;
        logic signed [RES_W-1:0] a_rem;
        logic signed [RES_W-1:0] b_rem;
        logic signed [RES_W-1:0] acc;
        logic [CNT_W-1:0]        cnt;
    } lane_bus_t;

    // One lane of the logic operations; trits are -1, 0, +1
    function automatic logic signed [1:0] lane_op(input logic [2:0] op,
                                                  input logic signed [1:0] a,
                                                  input logic signed [1:0] b);
        logic signed [2:0] s;
        logic signed [1:0] r;
        s = 3'sd0;
        r = 2'sd0;
        case (op)
            FUNC_AND: r = (a < b) ? a : b;
            FUNC_OR:  r = (a > b) ? a : b;
            FUNC_XOR: begin
                s = 3'(a) + 3'(b);
                if (s == 3'sd2) begin
                    r = -2'sd1;
                end else if (s == -3'sd2) begin
                    r = 2'sd1;
                end else begin
                    r = s[1:0];
                end
            end
            FUNC_IMP: begin
                s = 3'sd1 - 3'(a) + 3'(b);
                r = (s > 3'sd1) ? 2'sd1 : s[1:0];
            end
            default: r = (a > b) ? 2'sd1 : ((a < b) ? -2'sd1 : 2'sd0);
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/btl_front.sv */
// Input stage: saturates both words to the trit range and clamps the wanted trit.
module btl_front
    import btl_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [2:0]                  in_func,
    input  logic signed [OPERAND_W-1:0] in_a,
    input  logic signed [OPERAND_W-1:0] in_b,
    output logic                        out_valid,
    output lane_bus_t                   out_bus
);

    localparam logic signed [OPERAND_W-1:0] SAT_HI = OPERAND_W'(TRIT_MAX);
    localparam logic signed [OPERAND_W-1:0] SAT_LO = -OPERAND_W'(TRIT_MAX);

    logic                        valid_reg;
    lane_bus_t                   bus_reg;
    lane_bus_t                   bus_next;
    logic signed [OPERAND_W-1:0] a_sat;
    logic signed [OPERAND_W-1:0] b_sat;

    // Saturate and clamp
    always_comb begin
        a_sat = (in_a > SAT_HI) ? SAT_HI : ((in_a < SAT_LO) ? SAT_LO : in_a);
        b_sat = (in_b > SAT_HI) ? SAT_HI : ((in_b < SAT_LO) ? SAT_LO : in_b);
        bus_next.func  = in_func;
        bus_next.a_rem = a_sat[RES_W-1:0];
        bus_next.b_rem = b_sat[RES_W-1:0];
        bus_next.acc   = '0;
        bus_next.cnt   = '0;
        if (in_b > OPERAND_W'(1)) begin
            bus_next.want = 2'sd1;
        end else if (in_b < -OPERAND_W'(1)) begin
            bus_next.want = -2'sd1;
        end else begin
            bus_next.want = in_b[1:0];
        end
    end

    // Stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bus_reg <= bus_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_bus   = bus_reg;

endmodule

/* rtl/core/btl_cell.sv */
// One lane cell: peels the top trit off both words and folds the lane result in.
module btl_cell
    import btl_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic signed [RES_W-1:0] weight,
    input  logic                    in_valid,
    input  lane_bus_t               in_bus,
    output logic                    out_valid,
    output lane_bus_t               out_bus
);

    logic                    valid_reg;
    lane_bus_t               bus_reg;
    lane_bus_t               bus_next;
    logic signed [RES_W-1:0] bound;
    logic signed [1:0]       da;
    logic signed [1:0]       db;
    logic signed [1:0]       lane;

    // Digit of this lane: anything beyond the lower lanes' reach takes a trit
    always_comb begin
        bound = weight >>> 1;
        da = (in_bus.a_rem > bound) ? 2'sd1 : ((in_bus.a_rem < -bound) ? -2'sd1 : 2'sd0);
        db = (in_bus.b_rem > bound) ? 2'sd1 : ((in_bus.b_rem < -bound) ? -2'sd1 : 2'sd0);
        lane = lane_op(in_bus.func, da, db);

        bus_next      = in_bus;
        // Take the lane digit off each remainder: add or subtract one weight
        bus_next.a_rem = (da == 2'sd1) ? (in_bus.a_rem - weight)
                       : ((da == -2'sd1) ? (in_bus.a_rem + weight) : in_bus.a_rem);
        bus_next.b_rem = (db == 2'sd1) ? (in_bus.b_rem - weight)
                       : ((db == -2'sd1) ? (in_bus.b_rem + weight) : in_bus.b_rem);
        bus_next.acc   = (in_bus.acc <<< 1) + in_bus.acc + RES_W'(lane);
        bus_next.cnt   = in_bus.cnt + CNT_W'(da == in_bus.want);
    end

    // Stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bus_reg <= bus_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_bus   = bus_reg;

endmodule

/* rtl/core/balanced_ternary_lane_logic_unit_top.sv */
// Top level of the balanced-ternary lane logic unit: input stage, lane cell chain, output select.
//
// Each operation pair goes through an input stage and then a chain of TRIT_LANES cells, one per
// trit, most significant lane first; each cell takes the top trit off both saturated words by
// comparing against half of its lane weight, applies the lane operation and folds the trit into
// the running result (or the popcount). The input stage and every cell hold a register, and a
// new item is taken every cycle while m_ready is high or a stage ahead is empty: every stage moves
// as soon as the stage after it has room, so the chain keeps filling bubbles even while a finished
// result waits on m_ready. Codes 6 and 7 return zero.
module balanced_ternary_lane_logic_unit_top
    import btl_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [2:0]                  s_func,
    input  logic signed [OPERAND_W-1:0] s_operand_a,
    input  logic signed [OPERAND_W-1:0] s_operand_b,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [RES_W-1:0]     m_result
);

    logic      stage_valid [0:TRIT_LANES];
    lane_bus_t stage_bus   [0:TRIT_LANES];
    logic      stage_en    [0:TRIT_LANES+1];

    // A stage loads when it is empty or the next stage moves
    assign stage_en[TRIT_LANES+1] = m_ready;
    generate
        for (genvar k = 0; k <= TRIT_LANES; k++) begin : g_en
            assign stage_en[k] = !stage_valid[k] || stage_en[k+1];
        end
    endgenerate

    assign s_ready = stage_en[0];

    btl_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (stage_en[0]),
        .in_valid  (s_valid),
        .in_func   (s_func),
        .in_a      (s_operand_a),
        .in_b      (s_operand_b),
        .out_valid (stage_valid[0]),
        .out_bus   (stage_bus[0])
    );

    // Lane cells, top lane first
    generate
        for (genvar k = 0; k < TRIT_LANES; k++) begin : g_cell
            btl_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (stage_en[k+1]),
                .weight    (RES_W'(pow3(TRIT_LANES - 1 - k))),
                .in_valid  (stage_valid[k]),
                .in_bus    (stage_bus[k]),
                .out_valid (stage_valid[k+1]),
                .out_bus   (stage_bus[k+1])
            );
        end
    endgenerate

    // Output select
    assign m_valid = stage_valid[TRIT_LANES];
    always_comb begin
        case (stage_bus[TRIT_LANES].func)
            FUNC_AND, FUNC_OR, FUNC_XOR, FUNC_IMP, FUNC_CMP: m_result = stage_bus[TRIT_LANES].acc;
            FUNC_POP: m_result = RES_W'(stage_bus[TRIT_LANES].cnt);
            default:  m_result = '0;
        endcase
    end

    // An empty output lets the whole chain move
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output stage");

    // All trits must be consumed by the end of the chain
    a_rem_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (stage_bus[TRIT_LANES].a_rem == '0 && stage_bus[TRIT_LANES].b_rem == '0))
        else $error("trit remainder left after last lane");

    // Popcount never exceeds the lane count
    a_pop_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && stage_bus[TRIT_LANES].func == FUNC_POP) |-> (m_result <= RES_W'(TRIT_LANES)
            && m_result >= RES_W'(0)))
        else $error("popcount out of range");

    // An accepted transfer lands in the input stage
    a_accept_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> stage_valid[0])
        else $error("accepted transfer lost at input stage");

endmodule
